>>> rtl/core/aob_pkg.sv
// Shared types and constants for the ARGB source-over blend unit.
// Used by argb_over_blend_unit, aob_checker, aob_scoreboard and tb_top; depends on nothing else.
package aob_pkg;

  localparam int CHAN_W = 8;              // bits of one color or alpha component
  localparam int NUM_CHAN = 3;            // color components (blue, green, red)
  localparam int PIX_W = 32;              // one ARGB8888 pixel
  localparam int NUM_W = 2 * CHAN_W;      // weighted-sum numerator width
  localparam int QUO_BITS = CHAN_W;       // quotient bits, one per divider stage
  localparam int PRE_STAGES = 4;          // stages ahead of the divider
  localparam int NUM_STAGES = PRE_STAGES + QUO_BITS;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR = 8'h00;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_CHAN-1:0][NUM_W-1:0] num_vec_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] quo_vec_t;

endpackage

>>> rtl/core/argb_over_blend_unit.sv
// Porter-Duff source-over composite of two ARGB8888 pixels, fully pipelined.
// Depends on aob_pkg for widths, constants and types.
//
//  Channel  | Ports                              | Direction | Transfer when
//  ---------+------------------------------------+-----------+---------------------------
//  input    | in_valid, in_stall, in_fg_argb,    | in        | in_valid && !in_stall
//           | in_bg_argb                         |           |
//  result   | out_valid, out_stall, out_argb     | out       | out_valid && !out_stall
//
// One pixel pair enters per clock while the input is not stalled. A result passes
// through four arithmetic stages, an eight-stage restoring divider (one quotient
// bit per stage) and the output register: 13 registers in a row.
// Reset (rst_n, synchronous, active low) clears all valid bits; payload is not reset.
// A stall on the result side holds the output register, and bubbles inside the
// pipeline keep filling, so the input stalls only when every stage is occupied.
module argb_over_blend_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aob_pkg::pix_t       in_fg_argb,
  input  aob_pkg::pix_t       in_bg_argb,
  output logic                out_valid,
  input  logic                out_stall,
  output aob_pkg::pix_t       out_argb
);

  localparam int NST = aob_pkg::NUM_STAGES;
  localparam int QB = aob_pkg::QUO_BITS;
  localparam int NCH = aob_pkg::NUM_CHAN;
  localparam int CW = aob_pkg::CHAN_W;

  // Valid bit for each internal stage, plus the output register.
  logic [NST-1:0] vld_r;
  logic           out_valid_r;
  // rdy[k] is high when stage k may load this cycle; rdy[NST] is the output register.
  logic [NST:0]   rdy;

  // Stage 1: registered inputs and the background-alpha weight product ba*(255-a).
  aob_pkg::pix_t  s1_fg_r, s1_bg_r;
  aob_pkg::num_t  s1_prod_r;
  // Stage 2: scaled background alpha s and result alpha oa = a + s.
  aob_pkg::pix_t  s2_fg_r, s2_bg_r;
  aob_pkg::chan_t s2_a_r, s2_s_r, s2_oa_r;
  // Stage 3: the six per-channel products.
  aob_pkg::num_vec_t s3_pfa_r, s3_pbs_r;
  aob_pkg::chan_t    s3_oa_r;
  logic              s3_byp_r;
  aob_pkg::pix_t     s3_bg_r;
  // Stage 4: numerators of the final division.
  aob_pkg::num_vec_t s4_num_r;
  aob_pkg::chan_t    s4_oa_r;
  logic              s4_byp_r;
  aob_pkg::pix_t     s4_bg_r;
  // Divider stages, one quotient bit each, most significant bit first.
  aob_pkg::num_vec_t dv_rem_r [QB];
  aob_pkg::quo_vec_t dv_q_r   [QB];
  aob_pkg::chan_t    dv_oa_r  [QB];
  logic              dv_byp_r [QB];
  aob_pkg::pix_t     dv_bg_r  [QB];
  // Output register.
  aob_pkg::pix_t     out_argb_r;

  // Inputs of each divider stage, taken from the stage ahead of it.
  aob_pkg::num_vec_t dv_in_rem [QB];
  aob_pkg::quo_vec_t dv_in_q   [QB];
  aob_pkg::chan_t    dv_in_oa  [QB];
  logic              dv_in_byp [QB];
  aob_pkg::pix_t     dv_in_bg  [QB];
  aob_pkg::num_vec_t dv_rem_nxt [QB];
  aob_pkg::quo_vec_t dv_q_nxt   [QB];

  // Combinational values between stages.
  aob_pkg::chan_t    in_a, in_ia;
  logic [aob_pkg::NUM_W:0] div255_sum;
  aob_pkg::chan_t    s2_s_nxt;
  logic [CW:0]       s2_oa_wide;
  aob_pkg::num_vec_t s3_pfa_nxt, s3_pbs_nxt, s4_num_nxt;
  aob_pkg::pix_t     out_argb_nxt;

  // Ready chain: a stage may load when it is empty or its own content moves on.
  always_comb begin
    rdy[NST] = !out_valid_r || !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // Stage 1 logic: the weight product for the scaled background alpha.
  // With an opaque background this yields s = 255 - a and oa = 255, so the
  // general formula already covers that case exactly.
  always_comb begin
    in_a  = in_fg_argb[31:24];
    in_ia = aob_pkg::ALPHA_OPAQUE - in_a;
  end

  // Stage 2 logic: floor(x / 255) for x <= 65025 computed as (x + (x >> 8) + 1) >> 8.
  always_comb begin
    div255_sum = {1'b0, s1_prod_r} + {9'd0, s1_prod_r[15:8]} + 17'd1;
    s2_s_nxt   = div255_sum[15:8];
    s2_oa_wide = {1'b0, s1_fg_r[31:24]} + {1'b0, s2_s_nxt};
  end

  // Stage 3 and 4 logic: per-channel products, then their sums. Channel 0 is blue.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      s3_pfa_nxt[c] = s2_fg_r[c*CW +: CW] * s2_a_r;
      s3_pbs_nxt[c] = s2_bg_r[c*CW +: CW] * s2_s_r;
      // The sum never exceeds 255 * oa, so it fits the numerator width.
      s4_num_nxt[c] = s3_pfa_r[c] + s3_pbs_r[c];
    end
  end

  // Divider: stage j decides quotient bit QB-1-j by one compare and subtract.
  // The quotient always fits in eight bits because the numerator never exceeds 255 * oa.
  always_comb begin
    dv_in_rem[0] = s4_num_r;
    dv_in_q[0]   = '0;
    dv_in_oa[0]  = s4_oa_r;
    dv_in_byp[0] = s4_byp_r;
    dv_in_bg[0]  = s4_bg_r;
    for (int j = 1; j < QB; j++) begin
      dv_in_rem[j] = dv_rem_r[j-1];
      dv_in_q[j]   = dv_q_r[j-1];
      dv_in_oa[j]  = dv_oa_r[j-1];
      dv_in_byp[j] = dv_byp_r[j-1];
      dv_in_bg[j]  = dv_bg_r[j-1];
    end
  end

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      for (int c = 0; c < NCH; c++) begin
        logic [aob_pkg::NUM_W-1:0] trial;
        trial = {{(aob_pkg::NUM_W-CW){1'b0}}, dv_in_oa[j]} << (QB - 1 - j);
        dv_rem_nxt[j][c] = dv_in_rem[j][c];
        dv_q_nxt[j][c]   = dv_in_q[j][c];
        if (dv_in_rem[j][c] >= trial) begin
          dv_rem_nxt[j][c]          = dv_in_rem[j][c] - trial;
          dv_q_nxt[j][c][QB-1-j]    = 1'b1;
        end
      end
    end
  end

  // A transparent foreground passes the background through untouched; this also
  // avoids the zero divisor when both alphas are zero.
  always_comb begin
    if (dv_byp_r[QB-1]) begin
      out_argb_nxt = dv_bg_r[QB-1];
    end else begin
      out_argb_nxt = {dv_oa_r[QB-1], dv_q_r[QB-1][2], dv_q_r[QB-1][1], dv_q_r[QB-1][0]};
    end
  end

  // Valid bits travel with the data and are the only state cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[NST]) begin
        out_valid_r <= vld_r[NST-1];
      end
    end
  end

  // Payload registers load together with their valid bit.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_fg_r   <= in_fg_argb;
      s1_bg_r   <= in_bg_argb;
      s1_prod_r <= in_bg_argb[31:24] * in_ia;
    end
    if (rdy[1]) begin
      s2_fg_r <= s1_fg_r;
      s2_bg_r <= s1_bg_r;
      s2_a_r  <= s1_fg_r[31:24];
      s2_s_r  <= s2_s_nxt;
      s2_oa_r <= s2_oa_wide[CW-1:0];
    end
    if (rdy[2]) begin
      s3_pfa_r <= s3_pfa_nxt;
      s3_pbs_r <= s3_pbs_nxt;
      s3_oa_r  <= s2_oa_r;
      s3_byp_r <= (s2_a_r == aob_pkg::ALPHA_CLEAR);
      s3_bg_r  <= s2_bg_r;
    end
    if (rdy[3]) begin
      s4_num_r <= s4_num_nxt;
      s4_oa_r  <= s3_oa_r;
      s4_byp_r <= s3_byp_r;
      s4_bg_r  <= s3_bg_r;
    end
    for (int j = 0; j < QB; j++) begin
      if (rdy[aob_pkg::PRE_STAGES + j]) begin
        dv_rem_r[j] <= dv_rem_nxt[j];
        dv_q_r[j]   <= dv_q_nxt[j];
        dv_oa_r[j]  <= dv_in_oa[j];
        dv_byp_r[j] <= dv_in_byp[j];
        dv_bg_r[j]  <= dv_in_bg[j];
      end
    end
    if (rdy[NST]) begin
      out_argb_r <= out_argb_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_argb  = out_argb_r;

endmodule

>>> rtl/core/aob_checker.sv
// Port-level checks for argb_over_blend_unit and the bind that attaches them.
// Depends on aob_pkg for the pixel type.
module aob_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input aob_pkg::pix_t in_fg_argb,
  input aob_pkg::pix_t in_bg_argb,
  input logic          out_valid,
  input logic          out_stall,
  input aob_pkg::pix_t out_argb
);

  // Nothing is offered on the result side in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled input transfer stays offered with its payload unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_fg_argb) && $stable(in_bg_argb))
    else $error("stalled input changed or dropped");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_argb))
    else $error("stalled result changed or dropped");

  // The input can only stall when the pipeline is full, which needs a waiting result.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // With the result side free, the whole pipeline moves and the input is taken.
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the result side is free");

endmodule

bind argb_over_blend_unit aob_checker u_aob_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_fg_argb (in_fg_argb),
  .in_bg_argb (in_bg_argb),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_argb   (out_argb)
);

>>> dv/aob_checker.sv
// Scoreboard for argb_over_blend_unit: predicts each composited pixel and compares it.
// Depends on aob_pkg for the pixel type and the alpha constants.
module aob_scoreboard (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  aob_pkg::pix_t in_fg_argb,
  input  aob_pkg::pix_t in_bg_argb,
  input  logic          out_valid,
  input  logic          out_stall,
  input  aob_pkg::pix_t out_argb,
  output int            mismatches,
  output int            pixels_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = aob_pkg::PIX_W;
  localparam int CW = aob_pkg::CHAN_W;
  localparam int NCH = aob_pkg::NUM_CHAN;

  aob_pkg::pix_t expected_pixels[$];

  // Source-over composite with floor division, one component at a time.
  function automatic aob_pkg::pix_t composite_over(aob_pkg::pix_t fg, aob_pkg::pix_t bg);
    int unsigned fg_alpha;
    int unsigned bg_alpha;
    int unsigned inv_alpha;
    int unsigned scaled_bg;
    int unsigned out_alpha;
    int unsigned full;
    int unsigned f;
    int unsigned b;
    aob_pkg::pix_t res;
    fg_alpha = fg[PW-1 -: CW];
    bg_alpha = bg[PW-1 -: CW];
    full = aob_pkg::ALPHA_OPAQUE;
    inv_alpha = full - fg_alpha;
    if (fg_alpha == aob_pkg::ALPHA_CLEAR) begin
      return bg;
    end
    if (bg_alpha == aob_pkg::ALPHA_OPAQUE) begin
      res[PW-1 -: CW] = aob_pkg::ALPHA_OPAQUE;
      for (int c = 0; c < NCH; c++) begin
        f = fg[c*CW +: CW];
        b = bg[c*CW +: CW];
        res[c*CW +: CW] = aob_pkg::chan_t'((fg_alpha * f + inv_alpha * b) / full);
      end
      return res;
    end
    scaled_bg = (bg_alpha * inv_alpha) / full;
    out_alpha = fg_alpha + scaled_bg;
    res[PW-1 -: CW] = aob_pkg::chan_t'(out_alpha);
    for (int c = 0; c < NCH; c++) begin
      f = fg[c*CW +: CW];
      b = bg[c*CW +: CW];
      res[c*CW +: CW] = aob_pkg::chan_t'((f * fg_alpha + b * scaled_bg) / out_alpha);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // The result side is handled first so that a pixel entering on the same edge
  // can never be matched against a result leaving on it.
  always @(posedge clk) begin
    aob_pkg::pix_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %08h with nothing outstanding", out_argb));
        end else begin
          want = expected_pixels.pop_front();
          if (out_argb !== want) begin
            report_mismatch($sformatf("out_argb %08h, predicted %08h", out_argb, want));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(composite_over(in_fg_argb, in_bg_argb));
      end
      pixels_in_flight = expected_pixels.size();
    end
  end

endmodule

>>> dv/tb_top.sv
// Top of the argb_over_blend_unit testbench: clock, reset, stimulus and verdict.
// Depends on aob_pkg, argb_over_blend_unit and the aob_scoreboard checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = aob_pkg::PIX_W;
  localparam int CW = aob_pkg::CHAN_W;

  // Each random phase sends about a third of the random pixel pairs.
  localparam int PHASE_PIXELS = 510;
  // The receiver periodically refuses results for a long stretch so the
  // pipeline fills and the unit has to stall its input side.
  localparam int HOLD_PERIOD = 400;
  localparam int HOLD_LEN = 60;
  // Cycles without any transfer before the run is declared hung. This covers
  // the long hold above plus the worst random stall runs many times over.
  localparam int STALL_LIMIT = 2000;
  // Settling time at the end, once no pixel is outstanding.
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  aob_pkg::pix_t in_fg_argb = '0;
  aob_pkg::pix_t in_bg_argb = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  aob_pkg::pix_t out_argb;

  int mismatches;
  int pixels_in_flight;

  // Percentages that the stimulus process changes from phase to phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  argb_over_blend_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_fg_argb (in_fg_argb),
    .in_bg_argb (in_bg_argb),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_argb   (out_argb)
  );

  aob_scoreboard scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_fg_argb       (in_fg_argb),
    .in_bg_argb       (in_bg_argb),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_argb         (out_argb),
    .mismatches       (mismatches),
    .pixels_in_flight (pixels_in_flight)
  );

  // Offers one pixel pair, possibly after some idle cycles, and returns at the
  // edge where the transfer happens. Signals sampled right after the edge
  // still hold their values from just before it, which is what the unit saw.
  // The valid stays high on return so that back-to-back transfers need only a
  // single assignment per step.
  task automatic send_pixel(aob_pkg::pix_t fg, aob_pkg::pix_t bg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_fg_argb <= fg;
    in_bg_argb <= bg;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // Alphas are biased toward the values that select the special paths:
  // fully clear, fully opaque, and the values right next to them.
  function automatic aob_pkg::chan_t pick_alpha();
    case ($urandom_range(0, 5))
      0: return aob_pkg::ALPHA_CLEAR;
      1: return aob_pkg::ALPHA_OPAQUE;
      2: return aob_pkg::ALPHA_CLEAR + aob_pkg::chan_t'(1);
      3: return aob_pkg::ALPHA_OPAQUE - aob_pkg::chan_t'(1);
      default: return aob_pkg::chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_pixels(int count);
    aob_pkg::pix_t fg;
    aob_pkg::pix_t bg;
    for (int i = 0; i < count; i++) begin
      fg = $urandom();
      bg = $urandom();
      // Most pairs get steered alphas; the rest keep their fully random ones.
      if ($urandom_range(0, 3) != 0) begin
        fg[PW-1 -: CW] = pick_alpha();
        bg[PW-1 -: CW] = pick_alpha();
      end
      send_pixel(fg, bg);
    end
  endtask

  // The receiver decides its own stalls every cycle. A long hold also starts
  // periodically, regardless of phase; during the phase where the sender
  // never idles this is what backs the pipeline up into the input side.
  always @(posedge clk) begin
    static int recv_cycles = 0;
    static int hold_left = 0;
    recv_cycles++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_cycles % HOLD_PERIOD == 0) begin
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Hang detection: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    static int quiet_cycles = 0;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs, sent while both sides idle as in the first phase.
    send_idle_pct = 37;
    recv_stall_pct = 73;

    // Clear foreground: the background must come through untouched.
    send_pixel(32'h00FF_FFFF, 32'h1234_5678);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'h00AB_CDEF, 32'h80C0_4020);
    // Opaque background: result alpha is opaque, channels mix over 255.
    send_pixel(32'hFFFF_FFFF, 32'hFF00_0000);
    send_pixel(32'hFF00_0000, 32'hFFFF_FFFF);
    send_pixel(32'h01FF_FFFF, 32'hFF00_0000);
    send_pixel(32'h0100_0000, 32'hFFFF_FFFF);
    send_pixel(32'h80FF_00FF, 32'hFF00_FF00);
    send_pixel(32'hFEFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // General path: background alpha anywhere below opaque.
    send_pixel(32'h01FF_FFFF, 32'h0000_0000);
    send_pixel(32'h0100_0000, 32'h00FF_FFFF);
    send_pixel(32'h01FF_FFFF, 32'hFE00_0000);
    send_pixel(32'h0100_0000, 32'hFEFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'hFF00_0000, 32'hFEFF_FFFF);
    send_pixel(32'hFEFF_FFFF, 32'hFEFF_FFFF);
    send_pixel(32'h80FF_00FF, 32'h8000_FF00);
    send_pixel(32'h7F12_3456, 32'h01AB_CDEF);
    send_pixel(32'hFE00_0000, 32'h01FF_FFFF);

    // Sender idles often, receiver stalls more often still.
    send_random_pixels(PHASE_PIXELS);

    // The other way round: the receiver is mostly ready, the sender is sparse.
    send_idle_pct = 73;
    recv_stall_pct = 37;
    send_random_pixels(PHASE_PIXELS);

    // Full rate on both sides, apart from the periodic long holds.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_pixels(PHASE_PIXELS);
    in_valid <= 1'b0;

    // The scoreboard updates its counts at the rising edge, so they are read
    // at the falling edge to stay clear of that update.
    @(negedge clk);
    while (pixels_in_flight != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
